FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sspb_pkg.sv
// Package with the types, codes and reset constants of the proximity beeper.
package sspb_pkg;

   // Operation codes of an input transaction.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_SCAN   = 2'd1;
   localparam logic [1:0] OP_TOGGLE = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BEEP_LENGTH   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MISS_LIMIT    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_STRONG = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_GOOD   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_FAIR   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_WEAK   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_FAINT  = 3'd6;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Level band thresholds in dBm.
   localparam logic signed [7:0] LEVEL_STRONG = -8'sd60;
   localparam logic signed [7:0] LEVEL_GOOD   = -8'sd70;
   localparam logic signed [7:0] LEVEL_FAIR   = -8'sd80;
   localparam logic signed [7:0] LEVEL_WEAK   = -8'sd90;
   localparam logic signed [7:0] LEVEL_RESET  = -8'sd100;

   // Register reset values.
   localparam logic [15:0] BEEP_LENGTH_RESET   = 16'd100;
   localparam logic [3:0]  MISS_LIMIT_RESET    = 4'd5;
   localparam logic [15:0] PERIOD_STRONG_RESET = 16'd300;
   localparam logic [15:0] PERIOD_GOOD_RESET   = 16'd500;
   localparam logic [15:0] PERIOD_FAIR_RESET   = 16'd1000;
   localparam logic [15:0] PERIOD_WEAK_RESET   = 16'd2000;
   localparam logic [15:0] PERIOD_FAINT_RESET  = 16'd5000;

   // Default width of the elapsed-time counter.
   localparam int unsigned TIMER_WIDTH_DEFAULT = 17;

   typedef struct packed {
      logic [1:0]        operation;
      logic              networks_seen;
      logic              target_found;
      logic signed [7:0] level_dbm;
   } req_type;

   typedef struct packed {
      logic        buzzer_on;
      logic        tracking_active;
      logic        signal_lost;
      logic [15:0] beep_period_ms;
   } rsp_type;

endpackage

FILE: rtl/signal_strength_proximity_beeper.sv
// Top level of the signal-strength proximity beeper.
// A result transaction is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle; req_ready stays high while the result register
// is empty or its result is taken in the same cycle.
// Reset (synchronous, active high) restores the register defaults, turns tracking off,
// silences the beeper and saturates the elapsed-time counter.
`include "assert_macros.svh"

module signal_strength_proximity_beeper #(
   parameter int unsigned TIMER_WIDTH = sspb_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sspb_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sspb_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sspb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sspb_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   // The timer one constant and the zero-extension pad for the 16-bit periods.
   localparam logic [TIMER_WIDTH-1:0] TimerOne = TIMER_WIDTH'(1);
   localparam int unsigned PadWidth = TIMER_WIDTH - 16;

   // Configuration registers.
   logic [15:0] beep_length_ff;
   logic [3:0]  miss_limit_ff;
   logic [15:0] period_strong_ff;
   logic [15:0] period_good_ff;
   logic [15:0] period_fair_ff;
   logic [15:0] period_weak_ff;
   logic [15:0] period_faint_ff;

   // Tracking state and its next values.
   logic                   tracking_ff,   tracking_in;
   logic signed [7:0]      level_held_ff, level_held_in;
   logic [3:0]             miss_count_ff, miss_count_in;
   logic [TIMER_WIDTH-1:0] since_beep_ff, since_beep_in;
   logic                   beeper_ff,     beeper_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   sspb_pkg::rsp_type rsp_ff,       rsp_in;

   logic                   req_take;
   logic                   lost_now;
   logic [TIMER_WIDTH-1:0] since_inc;
   logic [15:0]            period_now;
   logic [15:0]            period_next;

   // The configuration port never stalls; the user must write only while the block is idle, which it does not enforce.
   assign csr_ready = 1'b1;

   // A new request enters whenever the result register is free or drains this cycle,
   // so the result register doubles as the stage that parts the two sides.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         beep_length_ff   <= sspb_pkg::BEEP_LENGTH_RESET;
         miss_limit_ff    <= sspb_pkg::MISS_LIMIT_RESET;
         period_strong_ff <= sspb_pkg::PERIOD_STRONG_RESET;
         period_good_ff   <= sspb_pkg::PERIOD_GOOD_RESET;
         period_fair_ff   <= sspb_pkg::PERIOD_FAIR_RESET;
         period_weak_ff   <= sspb_pkg::PERIOD_WEAK_RESET;
         period_faint_ff  <= sspb_pkg::PERIOD_FAINT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sspb_pkg::CSR_BEEP_LENGTH:   beep_length_ff   <= csr_data;
            sspb_pkg::CSR_MISS_LIMIT:    miss_limit_ff    <= csr_data[3:0];
            sspb_pkg::CSR_PERIOD_STRONG: period_strong_ff <= csr_data;
            sspb_pkg::CSR_PERIOD_GOOD:   period_good_ff   <= csr_data;
            sspb_pkg::CSR_PERIOD_FAIR:   period_fair_ff   <= csr_data;
            sspb_pkg::CSR_PERIOD_WEAK:   period_weak_ff   <= csr_data;
            sspb_pkg::CSR_PERIOD_FAINT:  period_faint_ff  <= csr_data;
            default: begin
               // Writes to an index past the register list are dropped.
            end
         endcase
      end
   end

   // Band selection, once for the level held now (timing of a tick) and once for
   // the level after this transaction (the reported period).
   function automatic logic [15:0] band_period(
      input logic signed [7:0] level,
      input logic [15:0]       p_strong,
      input logic [15:0]       p_good,
      input logic [15:0]       p_fair,
      input logic [15:0]       p_weak,
      input logic [15:0]       p_faint
   );
      logic [15:0] pick;
      priority if (level >= sspb_pkg::LEVEL_STRONG) pick = p_strong;
      else if (level >= sspb_pkg::LEVEL_GOOD)       pick = p_good;
      else if (level >= sspb_pkg::LEVEL_FAIR)       pick = p_fair;
      else if (level >= sspb_pkg::LEVEL_WEAK)       pick = p_weak;
      else                                          pick = p_faint;
      return pick;
   endfunction

   assign period_now = band_period(level_held_ff, period_strong_ff, period_good_ff,
                                   period_fair_ff, period_weak_ff, period_faint_ff);

   // The signal counts as lost while the miss count sits at or above the limit,
   // which also makes a zero limit mean permanently lost.
   assign lost_now  = (miss_count_ff >= miss_limit_ff);

   // Elapsed time advanced by one millisecond, held at all ones once saturated.
   assign since_inc = (&since_beep_ff) ? since_beep_ff : since_beep_ff + TimerOne;

   always_comb begin
      tracking_in   = tracking_ff;
      level_held_in = level_held_ff;
      miss_count_in = miss_count_ff;
      since_beep_in = since_beep_ff;
      beeper_in     = beeper_ff;

      if (req_take) begin
         unique case (req_data.operation)
            sspb_pkg::OP_TICK: begin
               since_beep_in = since_inc;
               if (tracking_ff && !lost_now) begin
                  // A beep starts once the period has been passed; otherwise an
                  // active beep ends once its length has been passed.
                  if (since_inc > {{PadWidth{1'b0}}, period_now}) begin
                     since_beep_in = '0;
                     beeper_in     = 1'b1;
                  end else if (beeper_ff &&
                               since_inc > {{PadWidth{1'b0}}, beep_length_ff}) begin
                     beeper_in = 1'b0;
                  end
               end
            end
            sspb_pkg::OP_SCAN: begin
               // Reports are ignored unless tracking and at least one network was seen.
               if (tracking_ff && req_data.networks_seen) begin
                  if (req_data.target_found) begin
                     level_held_in = req_data.level_dbm;
                     miss_count_in = '0;
                  end else if (miss_count_ff < miss_limit_ff) begin
                     // The count stays below the limit here, so it cannot wrap.
                     miss_count_in = miss_count_ff + 4'd1;
                     if (miss_count_in >= miss_limit_ff) begin
                        beeper_in = 1'b0;
                     end
                  end
               end
            end
            sspb_pkg::OP_TOGGLE: begin
               // Switching tracking on starts from the lost condition, so nothing
               // sounds until a report finds the target.
               if (!tracking_ff) begin
                  tracking_in   = 1'b1;
                  miss_count_in = miss_limit_ff;
               end else begin
                  tracking_in = 1'b0;
               end
               since_beep_in = '1;
               beeper_in     = 1'b0;
            end
            default: begin
               // The spare operation code changes nothing but still yields a result.
            end
         endcase
      end
   end

   assign period_next = band_period(level_held_in, period_strong_ff, period_good_ff,
                                    period_fair_ff, period_weak_ff, period_faint_ff);

   // The result reflects the state after the request has been applied.
   always_comb begin
      rsp_in                 = rsp_ff;
      rsp_valid_in           = rsp_valid_ff && !rsp_ready;
      if (req_take) begin
         rsp_valid_in           = 1'b1;
         rsp_in.buzzer_on       = beeper_in;
         rsp_in.tracking_active = tracking_in;
         rsp_in.signal_lost     = (miss_count_in >= miss_limit_ff);
         rsp_in.beep_period_ms  = period_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff   <= 1'b0;
         level_held_ff <= sspb_pkg::LEVEL_RESET;
         miss_count_ff <= sspb_pkg::MISS_LIMIT_RESET;
         since_beep_ff <= '1;
         beeper_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tracking_ff   <= tracking_in;
         level_held_ff <= level_held_in;
         miss_count_ff <= miss_count_in;
         since_beep_ff <= since_beep_in;
         beeper_ff     <= beeper_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // The payload register carries no reset: it is only read behind rsp_valid.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Concurrent checks on the block's own control logic.
   `ASSERT_SAME(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready, "request accepted while a stalled result waits")
   `ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_take, rsp_valid_ff, "accepted request produced no result")
   `ASSERT_NEXT(a_toggle_clears, clock, reset, req_take && req_data.operation == sspb_pkg::OP_TOGGLE, !beeper_ff && (&since_beep_ff), "toggle did not silence the beeper and saturate the timer")
   `ASSERT_SAME(a_idle_silent, clock, reset, !tracking_ff, !beeper_ff, "beeper on while tracking is off")

endmodule

FILE: tb/beeper_check_pkg.sv
// Shadow model and result checker for the proximity beeper testbench.
`timescale 1ns / 1ps

package beeper_check_pkg;
   import sspb_pkg::*;

   // Operation code with no meaning; the block must still answer it.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Register index with no register behind it.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;

   class beeper_scoreboard;
      // Register copies.
      logic [15:0] beep_length;
      logic [3:0]  miss_limit;
      logic [15:0] period_strong;
      logic [15:0] period_good;
      logic [15:0] period_fair;
      logic [15:0] period_weak;
      logic [15:0] period_faint;
      // Beeper state.
      logic                           tracking;
      logic signed [7:0]              level_held;
      logic [3:0]                     miss_count;
      logic [TIMER_WIDTH_DEFAULT-1:0] since_beep;
      logic                           beeper;
      // Outputs predicted for requests whose results have not yet been taken.
      rsp_type     predicted_outputs[$];
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned beeps_started;
      int unsigned targets_found;
      int unsigned lost_results;

      function new();
         beep_length   = BEEP_LENGTH_RESET;
         miss_limit    = MISS_LIMIT_RESET;
         period_strong = PERIOD_STRONG_RESET;
         period_good   = PERIOD_GOOD_RESET;
         period_fair   = PERIOD_FAIR_RESET;
         period_weak   = PERIOD_WEAK_RESET;
         period_faint  = PERIOD_FAINT_RESET;
         tracking      = 1'b0;
         level_held    = LEVEL_RESET;
         miss_count    = MISS_LIMIT_RESET;
         since_beep    = '1;
         beeper        = 1'b0;
         mismatches      = 0;
         results_checked = 0;
         beeps_started   = 0;
         targets_found   = 0;
         lost_results    = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index, logic [15:0] value);
         case (index)
            CSR_BEEP_LENGTH:   beep_length   = value;
            CSR_MISS_LIMIT:    miss_limit    = value[3:0];
            CSR_PERIOD_STRONG: period_strong = value;
            CSR_PERIOD_GOOD:   period_good   = value;
            CSR_PERIOD_FAIR:   period_fair   = value;
            CSR_PERIOD_WEAK:   period_weak   = value;
            CSR_PERIOD_FAINT:  period_faint  = value;
            default: ;
         endcase
      endfunction

      function logic [15:0] band_period();
         if (level_held >= LEVEL_STRONG) return period_strong;
         if (level_held >= LEVEL_GOOD) return period_good;
         if (level_held >= LEVEL_FAIR) return period_fair;
         if (level_held >= LEVEL_WEAK) return period_weak;
         return period_faint;
      endfunction

      function logic signal_is_lost();
         return miss_count >= miss_limit;
      endfunction

      // Applies one request to the shadow state and returns the outputs it leaves.
      function rsp_type next_beeper_output(req_type item);
         rsp_type outputs;
         case (item.operation)
            OP_TICK: begin
               if (since_beep != '1) since_beep = since_beep + 1'b1;
               if (tracking && !signal_is_lost()) begin
                  if (since_beep > band_period()) begin
                     since_beep = '0;
                     beeper     = 1'b1;
                     beeps_started++;
                  end else if (beeper && since_beep > beep_length) begin
                     beeper = 1'b0;
                  end
               end
            end
            OP_SCAN: begin
               if (tracking && item.networks_seen) begin
                  if (item.target_found) begin
                     level_held = item.level_dbm;
                     miss_count = '0;
                     targets_found++;
                  end else if (miss_count < miss_limit) begin
                     miss_count = miss_count + 4'd1;
                     if (miss_count >= miss_limit) beeper = 1'b0;
                  end
               end
            end
            OP_TOGGLE: begin
               if (!tracking) begin
                  tracking   = 1'b1;
                  miss_count = miss_limit;
               end else begin
                  tracking = 1'b0;
               end
               since_beep = '1;
               beeper     = 1'b0;
            end
            default: ;
         endcase
         outputs.buzzer_on       = beeper;
         outputs.tracking_active = tracking;
         outputs.signal_lost     = signal_is_lost();
         outputs.beep_period_ms  = band_period();
         return outputs;
      endfunction

      function void note_request(req_type item);
         predicted_outputs.push_back(next_beeper_output(item));
      endfunction

      function int unsigned pending_count();
         return predicted_outputs.size();
      endfunction

      task report(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task check_result(rsp_type seen);
         rsp_type want;
         if (predicted_outputs.size() == 0) begin
            report($sformatf("result %h arrived with no request outstanding", seen));
            return;
         end
         want = predicted_outputs.pop_front();
         results_checked++;
         if (want.signal_lost) lost_results++;
         if (seen.buzzer_on !== want.buzzer_on)
            report($sformatf("buzzer_on %b, expected %b", seen.buzzer_on, want.buzzer_on));
         if (seen.tracking_active !== want.tracking_active)
            report($sformatf("tracking_active %b, expected %b",
                             seen.tracking_active, want.tracking_active));
         if (seen.signal_lost !== want.signal_lost)
            report($sformatf("signal_lost %b, expected %b", seen.signal_lost, want.signal_lost));
         if (seen.beep_period_ms !== want.beep_period_ms)
            report($sformatf("beep_period_ms %0d, expected %0d",
                             seen.beep_period_ms, want.beep_period_ms));
      endtask
   endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench of the signal-strength proximity beeper.
`timescale 1ns / 1ps

module tb_top;
   import sspb_pkg::*;
   import beeper_check_pkg::*;

   // The run is abandoned as failed if it takes longer than this many cycles.
   localparam int unsigned CYCLE_LIMIT = 400000;
   // Length of the deliberate receiver hold-off that fills the block up.
   localparam int unsigned HOLD_OFF_CYCLES = 64;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_type                    req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_type                    rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   beeper_scoreboard beeper_shadow;

   // Whether tracking is on once every request sent so far has been applied.
   // The generator uses it to keep most scan reports meaningful.
   bit          tracking_sent;
   bit          hold_off_pending;
   int unsigned hold_offs_done;
   int unsigned settings_used;
   int unsigned cycle_count;

   signal_strength_proximity_beeper #(
      .TIMER_WIDTH(TIMER_WIDTH_DEFAULT)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog: a run that hangs, or crawls far beyond the slowest legal pace, fails.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Monitor. Everything is sampled at the rising edge, before the block's own
   // registers update, so a transaction is seen exactly when it completes. The
   // result is checked before a request accepted at the same edge is noted, as
   // that result always belongs to an earlier request.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) beeper_shadow.write_register(csr_index, csr_data);
         if (rsp_valid && rsp_ready) beeper_shadow.check_result(rsp_data);
         if (req_valid && req_ready) beeper_shadow.note_request(req_data);
      end
   end

   // Receiver. It runs through stretches of steady readiness, coin-toss
   // readiness, alternate-cycle readiness and outright stalls, and on request
   // holds off for a long stretch of its own counting. Exactly one assignment to
   // rsp_ready is made at each falling edge.
   initial begin : receiver
      int unsigned run_left;
      int unsigned style;
      int unsigned hold_left;
      logic        ready_next;
      rsp_ready = 1'b0;
      run_left  = 0;
      style     = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left        = HOLD_OFF_CYCLES - 1;
            hold_offs_done++;
            ready_next       = 1'b0;
         end else begin
            if (run_left == 0) begin
               style    = $urandom_range(3);
               run_left = (style == 2) ? $urandom_range(12, 1) : $urandom_range(30, 1);
            end
            run_left--;
            case (style)
               0:       ready_next = 1'b1;
               1:       ready_next = 1'($urandom_range(1));
               2:       ready_next = 1'b0;
               default: ready_next = run_left[0];
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   // Offers one request transaction and returns at the falling edge after it
   // has been accepted. Valid is left high so that a burst carries straight on.
   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.operation == OP_TOGGLE) tracking_sent = !tracking_sent;
      @(negedge clock);
   endtask

   // A gap between bursts; valid drops for the given number of cycles.
   task automatic sender_gap(input int unsigned cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // The sender holds back until every expected result has been taken; the block
   // presents each result in the cycle after it accepts the request and has nothing
   // else in flight.
   task automatic wait_for_idle();
      while (beeper_shadow.pending_count() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_one(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes every register while the block is idle. The spare index is written
   // too, and the unused upper bits of the miss limit carry random data.
   task automatic program_registers(input logic [15:0] beep, input logic [3:0] limit,
                                    input logic [15:0] strong_ms, input logic [15:0] good,
                                    input logic [15:0] fair, input logic [15:0] weak_ms,
                                    input logic [15:0] faint);
      wait_for_idle();
      write_one(CSR_BEEP_LENGTH, beep);
      write_one(CSR_MISS_LIMIT, {12'($urandom_range(4095)), limit});
      write_one(CSR_PERIOD_STRONG, strong_ms);
      write_one(CSR_PERIOD_GOOD, good);
      write_one(CSR_PERIOD_FAIR, fair);
      write_one(CSR_PERIOD_WEAK, weak_ms);
      write_one(CSR_PERIOD_FAINT, faint);
      write_one(CSR_UNUSED, 16'($urandom_range(65535)));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic req_type make_request(input logic [1:0] op, input logic seen,
                                            input logic found, input logic signed [7:0] level);
      req_type item;
      item.operation     = op;
      item.networks_seen = seen;
      item.target_found  = found;
      item.level_dbm     = level;
      return item;
   endfunction

   // Half the levels sit on either side of a band boundary; the rest cover the
   // whole signed range.
   function automatic logic signed [7:0] pick_level();
      if ($urandom_range(1) == 0) return 8'($urandom_range(255));
      case ($urandom_range(7))
         0:       return LEVEL_STRONG;
         1:       return LEVEL_STRONG - 8'sd1;
         2:       return LEVEL_GOOD;
         3:       return LEVEL_GOOD - 8'sd1;
         4:       return LEVEL_FAIR;
         5:       return LEVEL_FAIR - 8'sd1;
         6:       return LEVEL_WEAK;
         default: return LEVEL_WEAK - 8'sd1;
      endcase
   endfunction

   // Mostly ticks and scan reports while tracking, so that beeps start and end
   // and the miss count climbs to the limit and back; tracking is switched on
   // again soon after it has been switched off.
   function automatic req_type random_request();
      req_type     item;
      int unsigned pick;
      item = make_request(2'($urandom_range(3)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 8'($urandom_range(255)));
      pick = $urandom_range(99);
      if (!tracking_sent && pick < 30) begin
         item.operation = OP_TOGGLE;
      end else if (pick < 3) begin
         item.operation = OP_UNUSED;
      end else if (pick < 5) begin
         item.operation = OP_TOGGLE;
      end else if (pick < 35) begin
         item.operation     = OP_SCAN;
         item.networks_seen = ($urandom_range(9) != 0);
         item.target_found  = ($urandom_range(99) < 55);
         item.level_dbm     = pick_level();
      end else begin
         item.operation = OP_TICK;
      end
      return item;
   endfunction

   // Bursts of random length with random gaps, some of them none at all. Only
   // requests that can change the block's state count towards the target.
   task automatic run_random_phase(input int unsigned item_target);
      int unsigned counted;
      int unsigned burst_left;
      req_type     item;
      counted    = 0;
      burst_left = 0;
      while (counted < item_target) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            sender_gap(($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1));
         end
         item = random_request();
         if (!(item.operation == OP_UNUSED ||
               (item.operation == OP_SCAN && (!tracking_sent || !item.networks_seen))))
            counted++;
         send_item(item);
         burst_left--;
      end
      req_valid <= 1'b0;
   endtask

   initial begin : stimulus
      beeper_shadow    = new();
      tracking_sent    = 1'b0;
      hold_off_pending = 1'b0;
      hold_offs_done   = 0;
      settings_used    = 0;
      cycle_count      = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: the level starts in the faintest band and the miss count
      // at the limit. A scan report is ignored while not tracking, and the
      // unused operation code changes nothing but is still answered.
      send_item(make_request(OP_TICK, 1'b0, 1'b0, 8'sd0));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, 8'sd127));
      send_item(make_request(OP_UNUSED, 1'b1, 1'b1, -8'sd1));
      req_valid <= 1'b0;

      // Short periods so that the directed sequence sees beeps start and end.
      program_registers(16'd2, 4'd3, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7);
      send_item(make_request(OP_TOGGLE, 1'b0, 1'b0, 8'sd0));
      // Still lost after switching on, so this tick leaves the beeper alone.
      send_item(make_request(OP_TICK, 1'b1, 1'b1, 8'sd0));
      // A report with no networks is ignored even though the target flag is set.
      send_item(make_request(OP_SCAN, 1'b0, 1'b1, LEVEL_STRONG));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, LEVEL_STRONG));
      // The saturated counter starts a beep at once; it ends past the beep
      // length and the next one starts past the period.
      repeat (5) send_item(make_request(OP_TICK, 1'b0, 1'b0, 8'sd0));
      // Misses up to the limit silence the beeper; a further miss and a tick
      // then change nothing.
      repeat (4) send_item(make_request(OP_SCAN, 1'b1, 1'b0, -8'sd128));
      send_item(make_request(OP_TICK, 1'b0, 1'b0, 8'sd0));
      // Both sides of every band boundary, then the extremes of the level.
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, LEVEL_STRONG - 8'sd1));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, LEVEL_GOOD));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, LEVEL_GOOD - 8'sd1));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, LEVEL_FAIR));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, LEVEL_FAIR - 8'sd1));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, LEVEL_WEAK));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, LEVEL_WEAK - 8'sd1));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, -8'sd128));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, 8'sd127));
      send_item(make_request(OP_TOGGLE, 1'b1, 1'b1, 8'sd127));
      send_item(make_request(OP_TOGGLE, 1'b0, 1'b0, 8'sd0));
      send_item(make_request(OP_SCAN, 1'b1, 1'b1, 8'sd0));
      // This tick leaves the beeper sounding for the next register write.
      send_item(make_request(OP_TICK, 1'b0, 1'b0, 8'sd0));
      req_valid <= 1'b0;

      // The limit drops to zero while the beeper is on: the signal always
      // counts as lost and the beeper stays on until a toggle.
      program_registers(16'd0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_random_phase(80);

      // Small periods; the receiver holds off for a long stretch early on while
      // the sender keeps offering, so the block fills and stalls its input.
      program_registers(16'd3, 4'd4, 16'd5, 16'd8, 16'd12, 16'd20, 16'd30);
      hold_off_pending = 1'b1;
      run_random_phase(220);

      // Zero periods: every tick while tracking and not lost restarts a beep.
      program_registers(16'd0, 4'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_random_phase(120);

      // Largest values: a beep starts only from the saturated counter and
      // never ends within the phase.
      program_registers(16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_phase(80);

      program_registers(16'd1, 4'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      run_random_phase(150);

      repeat (3) begin
         program_registers(16'($urandom_range(12)), 4'($urandom_range(15, 1)),
                           16'($urandom_range(40)), 16'($urandom_range(40)),
                           16'($urandom_range(40)), 16'($urandom_range(40)),
                           16'($urandom_range(40)));
         run_random_phase(200);
      end

      program_registers(BEEP_LENGTH_RESET, MISS_LIMIT_RESET, PERIOD_STRONG_RESET,
                        PERIOD_GOOD_RESET, PERIOD_FAIR_RESET, PERIOD_WEAK_RESET,
                        PERIOD_FAINT_RESET);
      run_random_phase(100);

      wait_for_idle();
      repeat (4) @(negedge clock);

      $display("Checked %0d result transactions over %0d register settings, with %0d long hold-off(s).",
               beeper_shadow.results_checked, settings_used, hold_offs_done);
      $display("Beeps started: %0d; scan reports finding the target: %0d; lost results: %0d.",
               beeper_shadow.beeps_started, beeper_shadow.targets_found,
               beeper_shadow.lost_results);
      if (beeper_shadow.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
